>>> hw/rtl/fts_pkg.sv
package fts_pkg;

	// Store sizes
	localparam int TASK_QUEUE_DEPTH = 64;
	localparam int CPU_COUNT        = 16;
	localparam int TASK_ID_BITS     = 16;

	// Field widths
	localparam int MODE_W = 3;
	localparam int CPU_W  = 4;

	// Derived pointer and count widths
	localparam int QAW = (TASK_QUEUE_DEPTH > 1) ? $clog2(TASK_QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(TASK_QUEUE_DEPTH + 1);
	localparam int IAW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
	localparam int ICW = $clog2(CPU_COUNT + 1);

	// Request codes
	localparam logic [MODE_W-1:0] MODE_ADD_READY = 3'd0;
	localparam logic [MODE_W-1:0] MODE_UNBLOCK   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_REQUEST   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_GRANT     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FIND_IDLE = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0]       mode;
		logic [TASK_ID_BITS-1:0] task_id;
		logic [CPU_W-1:0]        cpu_id;
		logic                    force_req;
	} fts_req_t;

	typedef struct packed {
		logic                    task_valid;
		logic [TASK_ID_BITS-1:0] task_out;
		logic                    from_unblocked;
		logic                    cpu_valid;
		logic [CPU_W-1:0]        cpu_out;
		logic                    granted;
		logic                    overflow;
	} fts_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RDATA,
		ST_SRCH,
		ST_SHIFT,
		ST_DONE
	} fts_state_t;

	// Controller -> datapath
	typedef struct packed {
		logic load_req;
		logic push_ready;
		logic push_unb;
		logic pop_ready;
		logic pop_unb;
		logic push_idle;
		logic pop_idle;
		logic srch_start;
		logic srch_next;
		logic shift_start;
		logic shift_step;
		logic dec_idle;
		logic set_grant;
		logic capture;
		logic load_out;
	} fts_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              force_req;
		logic              ready_empty;
		logic              unb_empty;
		logic              idle_empty;
		logic              srch_match;
		logic              srch_bottom;
		logic              srch_top;
		logic              shift_last;
		logic              out_free;
	} fts_sts_t;

endpackage

>>> hw/rtl/fts_ram.sv
module fts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/fts_ctrl.sv
module fts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  fts_pkg::fts_sts_t sts,
	output fts_pkg::fts_cmd_t cmd
);

	fts_pkg::fts_state_t state_q, state_d;
	logic                task_waits;

	assign task_waits = sts.force_req || !sts.ready_empty || !sts.unb_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fts_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = fts_pkg::ST_EXEC;
				end
			end
			fts_pkg::ST_EXEC: begin
				unique case (sts.mode)
					fts_pkg::MODE_ADD_READY:
						state_d = sts.idle_empty ? fts_pkg::ST_DONE : fts_pkg::ST_RDATA;
					fts_pkg::MODE_REQUEST:
						state_d = (sts.unb_empty && sts.ready_empty) ? fts_pkg::ST_DONE
							: fts_pkg::ST_RDATA;
					fts_pkg::MODE_GRANT:
						state_d = sts.idle_empty ? fts_pkg::ST_DONE : fts_pkg::ST_SRCH;
					fts_pkg::MODE_FIND_IDLE:
						state_d = (task_waits && !sts.idle_empty) ? fts_pkg::ST_RDATA
							: fts_pkg::ST_DONE;
					default:
						state_d = fts_pkg::ST_DONE;
				endcase
			end
			fts_pkg::ST_RDATA: begin
				state_d = fts_pkg::ST_DONE;
			end
			fts_pkg::ST_SRCH: begin
				if (sts.srch_match) begin
					state_d = sts.srch_top ? fts_pkg::ST_DONE : fts_pkg::ST_SHIFT;
				end else if (sts.srch_bottom) begin
					state_d = fts_pkg::ST_DONE;
				end
			end
			fts_pkg::ST_SHIFT: begin
				if (sts.shift_last) begin
					state_d = fts_pkg::ST_DONE;
				end
			end
			fts_pkg::ST_DONE: begin
				if (sts.out_free) begin
					state_d = fts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fts_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			fts_pkg::ST_IDLE: begin
				req_ready    = 1'b1;
				cmd.load_req = req_valid;
			end
			fts_pkg::ST_EXEC: begin
				unique case (sts.mode)
					fts_pkg::MODE_ADD_READY: begin
						cmd.push_ready = 1'b1;
						cmd.pop_idle   = !sts.idle_empty;
					end
					fts_pkg::MODE_UNBLOCK: begin
						cmd.push_unb = 1'b1;
					end
					fts_pkg::MODE_REQUEST: begin
						if (!sts.unb_empty) begin
							cmd.pop_unb = 1'b1;
						end else if (!sts.ready_empty) begin
							cmd.pop_ready = 1'b1;
						end else begin
							cmd.push_idle = 1'b1;
						end
					end
					fts_pkg::MODE_GRANT: begin
						cmd.srch_start = !sts.idle_empty;
					end
					fts_pkg::MODE_FIND_IDLE: begin
						cmd.pop_idle = task_waits && !sts.idle_empty;
					end
					default: begin
					end
				endcase
			end
			fts_pkg::ST_RDATA: begin
				cmd.capture = 1'b1;
			end
			fts_pkg::ST_SRCH: begin
				if (sts.srch_match) begin
					cmd.set_grant   = 1'b1;
					cmd.dec_idle    = sts.srch_top;
					cmd.shift_start = !sts.srch_top;
				end else begin
					cmd.srch_next = !sts.srch_bottom;
				end
			end
			fts_pkg::ST_SHIFT: begin
				cmd.shift_step = 1'b1;
				cmd.dec_idle   = sts.shift_last;
			end
			fts_pkg::ST_DONE: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> hw/rtl/fts_datapath.sv
module fts_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  fts_pkg::fts_req_t req,
	input  fts_pkg::fts_cmd_t cmd,
	output fts_pkg::fts_sts_t sts,
	input  logic              rsp_ready,
	output logic              rsp_valid,
	output fts_pkg::fts_rsp_t rsp
);

	localparam int QAW = fts_pkg::QAW;
	localparam int QCW = fts_pkg::QCW;
	localparam int QSW = fts_pkg::QCW + 1;
	localparam int IAW = fts_pkg::IAW;
	localparam int ICW = fts_pkg::ICW;
	localparam int TW  = fts_pkg::TASK_ID_BITS;
	localparam int CW  = fts_pkg::CPU_W;

	// Tail slot of a circular queue; head + count stays below twice the depth
	function automatic logic [QAW-1:0] q_tail(input logic [QAW-1:0] head,
			input logic [QCW-1:0] count);
		logic [QSW-1:0] sum;
		sum = QSW'(head) + QSW'(count);
		if (sum >= QSW'(fts_pkg::TASK_QUEUE_DEPTH)) begin
			sum = sum - QSW'(fts_pkg::TASK_QUEUE_DEPTH);
		end
		return QAW'(sum);
	endfunction

	function automatic logic [QAW-1:0] q_next(input logic [QAW-1:0] head);
		return (head == QAW'(fts_pkg::TASK_QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
	endfunction

	fts_pkg::fts_req_t req_q;

	logic [QAW-1:0] rdy_head_q, unb_head_q;
	logic [QCW-1:0] rdy_cnt_q, unb_cnt_q;
	logic [ICW-1:0] idle_cnt_q;
	logic [IAW-1:0] sidx_q;

	logic          res_tv_q, res_fu_q, res_cv_q, res_gr_q, res_ov_q;
	logic [TW-1:0] res_task_q;
	logic [CW-1:0] res_cpu_q;

	logic              out_valid_q;
	fts_pkg::fts_rsp_t out_q;

	logic rdy_full, unb_full, idle_full;

	logic          rdy_we, unb_we;
	logic [TW-1:0] rdy_rdata, unb_rdata;

	logic           stk_we, stk_re;
	logic [IAW-1:0] stk_waddr, stk_raddr, stk_top;
	logic [CW-1:0]  stk_wdata, stk_rdata;

	assign rdy_full  = rdy_cnt_q == QCW'(fts_pkg::TASK_QUEUE_DEPTH);
	assign unb_full  = unb_cnt_q == QCW'(fts_pkg::TASK_QUEUE_DEPTH);
	assign idle_full = idle_cnt_q == ICW'(fts_pkg::CPU_COUNT);
	assign stk_top   = IAW'(idle_cnt_q - 1'b1);

	assign rdy_we = cmd.push_ready && !rdy_full;
	assign unb_we = cmd.push_unb && !unb_full;

	// Task queues
	fts_ram #(.WIDTH(TW), .DEPTH(fts_pkg::TASK_QUEUE_DEPTH)) u_rdy_ram (
		.clk   (clk),
		.we    (rdy_we),
		.waddr (q_tail(rdy_head_q, rdy_cnt_q)),
		.wdata (req_q.task_id),
		.re    (cmd.pop_ready),
		.raddr (rdy_head_q),
		.rdata (rdy_rdata)
	);

	fts_ram #(.WIDTH(TW), .DEPTH(fts_pkg::TASK_QUEUE_DEPTH)) u_unb_ram (
		.clk   (clk),
		.we    (unb_we),
		.waddr (q_tail(unb_head_q, unb_cnt_q)),
		.wdata (req_q.task_id),
		.re    (cmd.pop_unb),
		.raddr (unb_head_q),
		.rdata (unb_rdata)
	);

	// Idle CPU stack: push/pop at the top, plus search and compaction
	always_comb begin
		stk_we    = (cmd.push_idle && !idle_full) || cmd.shift_step;
		stk_waddr = cmd.shift_step ? sidx_q : IAW'(idle_cnt_q);
		stk_wdata = cmd.shift_step ? stk_rdata : req_q.cpu_id;
		stk_re    = 1'b0;
		stk_raddr = stk_top;
		if (cmd.pop_idle || cmd.srch_start) begin
			stk_re = 1'b1;
		end else if (cmd.srch_next) begin
			stk_re    = 1'b1;
			stk_raddr = sidx_q - 1'b1;
		end else if (cmd.shift_start) begin
			stk_re    = 1'b1;
			stk_raddr = sidx_q + 1'b1;
		end else if (cmd.shift_step) begin
			stk_re    = !sts.shift_last;
			stk_raddr = IAW'(sidx_q + 2'd2);
		end
	end

	fts_ram #(.WIDTH(CW), .DEPTH(fts_pkg::CPU_COUNT)) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Request register
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
	end

	// Queue and stack pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_head_q <= '0;
			rdy_cnt_q  <= '0;
			unb_head_q <= '0;
			unb_cnt_q  <= '0;
			idle_cnt_q <= '0;
		end else begin
			if (rdy_we) begin
				rdy_cnt_q <= rdy_cnt_q + 1'b1;
			end else if (cmd.pop_ready) begin
				rdy_head_q <= q_next(rdy_head_q);
				rdy_cnt_q  <= rdy_cnt_q - 1'b1;
			end
			if (unb_we) begin
				unb_cnt_q <= unb_cnt_q + 1'b1;
			end else if (cmd.pop_unb) begin
				unb_head_q <= q_next(unb_head_q);
				unb_cnt_q  <= unb_cnt_q - 1'b1;
			end
			if (cmd.push_idle && !idle_full) begin
				idle_cnt_q <= idle_cnt_q + 1'b1;
			end else if (cmd.pop_idle || cmd.dec_idle) begin
				idle_cnt_q <= idle_cnt_q - 1'b1;
			end
		end
	end

	// Search index
	always_ff @(posedge clk) begin
		if (cmd.srch_start) begin
			sidx_q <= stk_top;
		end else if (cmd.srch_next) begin
			sidx_q <= sidx_q - 1'b1;
		end else if (cmd.shift_step) begin
			sidx_q <= sidx_q + 1'b1;
		end
	end

	// Result fields, cleared per request
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			res_tv_q   <= 1'b0;
			res_fu_q   <= 1'b0;
			res_cv_q   <= 1'b0;
			res_gr_q   <= 1'b0;
			res_ov_q   <= 1'b0;
			res_task_q <= '0;
			res_cpu_q  <= '0;
		end else begin
			if ((cmd.push_ready && rdy_full) || (cmd.push_unb && unb_full)
					|| (cmd.push_idle && idle_full)) begin
				res_ov_q <= 1'b1;
			end
			if (cmd.pop_unb) begin
				res_tv_q <= 1'b1;
				res_fu_q <= 1'b1;
			end
			if (cmd.pop_ready) begin
				res_tv_q <= 1'b1;
			end
			if (cmd.pop_idle) begin
				res_cv_q <= 1'b1;
			end
			if (cmd.set_grant) begin
				res_gr_q <= 1'b1;
			end
			if (cmd.capture) begin
				if (res_cv_q) begin
					res_cpu_q <= stk_rdata;
				end else begin
					res_task_q <= res_fu_q ? unb_rdata : rdy_rdata;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.task_valid     <= res_tv_q;
			out_q.task_out       <= res_task_q;
			out_q.from_unblocked <= res_fu_q;
			out_q.cpu_valid      <= res_cv_q;
			out_q.cpu_out        <= res_cpu_q;
			out_q.granted        <= res_gr_q;
			out_q.overflow       <= res_ov_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Status
	assign sts.mode        = req_q.mode;
	assign sts.force_req   = req_q.force_req;
	assign sts.ready_empty = rdy_cnt_q == '0;
	assign sts.unb_empty   = unb_cnt_q == '0;
	assign sts.idle_empty  = idle_cnt_q == '0;
	assign sts.srch_match  = stk_rdata == req_q.cpu_id;
	assign sts.srch_bottom = sidx_q == '0;
	assign sts.srch_top    = (ICW'(sidx_q) + 1'b1) == idle_cnt_q;
	assign sts.shift_last  = (ICW'(sidx_q) + ICW'(2)) == idle_cnt_q;
	assign sts.out_free    = !out_valid_q || rsp_ready;

endmodule

>>> hw/rtl/fifo_task_scheduler_top.sv
// Task scheduler with two FIFO queues of task ids (ready and unblocked, each
// TASK_QUEUE_DEPTH deep) and a LIFO stack of idle CPU ids (CPU_COUNT deep).
// Every request transaction on req yields exactly one result transaction on
// rsp. Modes: 0 queues a ready task and pops an idle CPU to wake, 1 queues an
// unblocked task, 2 hands a CPU the oldest unblocked task, else the oldest
// ready task, else pushes the CPU idle, 3 removes a CPU from the idle stack
// (nearest copy to the top, order of the rest kept) and reports granted,
// 4 pops an idle CPU when forced or when any task waits. Modes 5 to 7 change
// nothing and return all zeros. A push into a full store drops the item and
// sets overflow for that result only. One request is handled at a time:
// modes 0, 1, 2 and 4 pass through execute, a read state when a store is
// read, and emit; mode 3 examines stack entries from the top down until a
// match or the bottom, then moves each entry above the match down one slot.
// The idle stack memory has a single read port, read one entry per cycle
// during search and compaction. The result sits in an output register, so
// the next request is taken while the previous result is still waiting for
// rsp_ready. No clearing pass is needed after reset: all stores are tracked
// by head pointers and occupancy counts.
module fifo_task_scheduler_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  fts_pkg::fts_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output fts_pkg::fts_rsp_t rsp
);

	fts_pkg::fts_cmd_t cmd;
	fts_pkg::fts_sts_t sts;

	// Sequencer: accept, execute, wait for memory reads, search/compact, emit
	fts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Queues, idle stack, pointers, result and output registers
	fts_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

>>> hw/rtl/fts_checker.sv
module fts_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input fts_pkg::fts_rsp_t rsp
);

	// A stalled result transaction holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// One request in flight: no accept in the cycle right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	// Task fields are zero unless a task was handed out
	a_task_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.task_valid |-> rsp.task_out == '0 && !rsp.from_unblocked)
		else $error("task fields set without task_valid");

	// CPU id is zero unless a CPU was popped
	a_cpu_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.cpu_valid |-> rsp.cpu_out == '0)
		else $error("cpu_out set without cpu_valid");

	// A result reports at most one of task, CPU and grant
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot0({rsp.task_valid, rsp.cpu_valid, rsp.granted}))
		else $error("conflicting result flags");

endmodule

bind fifo_task_scheduler_top fts_checker u_fts_checker (.*);

>>> test/fifo_task_scheduler_top_tb.sv
module fifo_task_scheduler_top_tb;
	import fts_pkg::*;

	// Request codes above the five used ones: the block must ignore them
	localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RSVD_HI = 3'd7;

	localparam logic [TASK_ID_BITS-1:0] TASK_MAX = '1;
	localparam logic [CPU_W-1:0]        CPU_MAX  = '1;

	// Worst single request is a grant that scans and compacts the whole stack
	localparam int SLOWEST_REQ = 2 * CPU_COUNT + 2;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 1575;

	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_RUNS
	} rx_style_t;

	typedef enum int {
		MIX_BALANCED,
		MIX_FILL,
		MIX_DRAIN
	} mix_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	fts_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	fts_rsp_t rsp;

	fifo_task_scheduler_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the scheduler stores. Index 0 of idle_cpus is the stack
	// bottom, the last entry is the top.
	logic [TASK_ID_BITS-1:0] ready_tasks[$];
	logic [TASK_ID_BITS-1:0] unblocked_tasks[$];
	logic [CPU_W-1:0]        idle_cpus[$];

	// Results owed by the block, oldest first
	fts_rsp_t awaited_rsp[$];

	int fail_count   = 0;
	int reqs_sent    = 0;
	int rsps_checked = 0;
	int stall_cycles = 0;
	int overflows    = 0;
	int grants       = 0;
	int cycle_count  = 0;

	// Sender pacing
	bit sender_bursty = 1'b1;
	int burst_left    = 0;

	// Receiver pacing; a long hold is requested by bumping hold_seq
	rx_style_t rx_style = RX_ALWAYS;
	int hold_seq  = 0;
	int hold_len  = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int run_left  = 0;
	bit run_stall = 1'b0;

	// Applies one request to the shadow stores and returns the result the
	// block has to produce for it.
	function automatic fts_rsp_t sched_outcome(input fts_req_t r);
		fts_rsp_t o;
		int       slot;
		bit       hit;
		o = '0;
		case (r.mode)
		MODE_ADD_READY: begin
			// a full queue drops the task but still wakes an idle CPU
			if (ready_tasks.size() >= TASK_QUEUE_DEPTH)
				o.overflow = 1'b1;
			else
				ready_tasks.insert(ready_tasks.size(), r.task_id);
			if (idle_cpus.size() != 0) begin
				o.cpu_valid = 1'b1;
				o.cpu_out   = idle_cpus.pop_back();
			end
		end
		MODE_UNBLOCK: begin
			if (unblocked_tasks.size() >= TASK_QUEUE_DEPTH)
				o.overflow = 1'b1;
			else
				unblocked_tasks.insert(unblocked_tasks.size(), r.task_id);
		end
		MODE_REQUEST: begin
			// unblocked work wins over ready work; no work parks the CPU
			if (unblocked_tasks.size() != 0) begin
				o.task_valid     = 1'b1;
				o.from_unblocked = 1'b1;
				o.task_out       = unblocked_tasks[0];
				unblocked_tasks.delete(0);
			end else if (ready_tasks.size() != 0) begin
				o.task_valid = 1'b1;
				o.task_out   = ready_tasks[0];
				ready_tasks.delete(0);
			end else if (idle_cpus.size() >= CPU_COUNT) begin
				o.overflow = 1'b1;
			end else begin
				idle_cpus.insert(idle_cpus.size(), r.cpu_id);
			end
		end
		MODE_GRANT: begin
			// search from the top; only the nearest copy goes
			slot = idle_cpus.size() - 1;
			hit  = 1'b0;
			while (slot >= 0 && !hit) begin
				if (idle_cpus[slot] == r.cpu_id) begin
					idle_cpus.delete(slot);
					hit = 1'b1;
				end else begin
					slot--;
				end
			end
			o.granted = hit;
		end
		MODE_FIND_IDLE: begin
			if ((r.force_req || ready_tasks.size() != 0 || unblocked_tasks.size() != 0)
					&& idle_cpus.size() != 0) begin
				o.cpu_valid = 1'b1;
				o.cpu_out   = idle_cpus.pop_back();
			end
		end
		default: begin
		end
		endcase
		return o;
	endfunction

	function automatic fts_req_t req_of(input logic [MODE_W-1:0] m,
			input logic [TASK_ID_BITS-1:0] t, input logic [CPU_W-1:0] c, input logic f);
		fts_req_t r;
		r.mode      = m;
		r.task_id   = t;
		r.cpu_id    = c;
		r.force_req = f;
		return r;
	endfunction

	// Random request; the mix biases toward filling or draining the stores
	function automatic fts_req_t rand_req(input mix_t mix);
		fts_req_t r;
		int       w, t0, t1, t2, t3, t4;
		r.task_id   = TASK_ID_BITS'($urandom);
		r.cpu_id    = CPU_W'($urandom);
		r.force_req = 1'($urandom);
		case (mix)
		MIX_FILL: begin
			t0 = 40; t1 = 70; t2 = 82; t3 = 90; t4 = 97;
		end
		MIX_DRAIN: begin
			t0 = 12; t1 = 20; t2 = 70; t3 = 85; t4 = 96;
		end
		default: begin
			t0 = 25; t1 = 40; t2 = 70; t3 = 85; t4 = 96;
		end
		endcase
		w = $urandom_range(0, 99);
		if (w < t0)
			r.mode = MODE_ADD_READY;
		else if (w < t1)
			r.mode = MODE_UNBLOCK;
		else if (w < t2)
			r.mode = MODE_REQUEST;
		else if (w < t3)
			r.mode = MODE_GRANT;
		else if (w < t4)
			r.mode = MODE_FIND_IDLE;
		else
			r.mode = MODE_W'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
		// most grants ask for a CPU that really is parked, anywhere in the stack
		if (r.mode == MODE_GRANT && idle_cpus.size() != 0 && $urandom_range(0, 2) != 0)
			r.cpu_id = idle_cpus[$urandom_range(0, idle_cpus.size() - 1)];
		return r;
	endfunction

	// Offers one request and returns at the edge that accepts it. In bursty
	// mode valid drops for a random gap at the start of each burst.
	task automatic send_req(input fts_req_t r);
		int gap;
		if (sender_bursty) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					req_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		awaited_rsp.insert(awaited_rsp.size(), sched_outcome(r));
		reqs_sent++;
	endtask

	// Called right after an accept: nothing more is offered until the next send
	task automatic wait_drain();
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0) @(posedge clk);
	endtask

	// Receiver: long hold first, otherwise the current stall pattern
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = hold_len;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			case (rx_style)
			RX_COIN:
				rsp_ready <= 1'($urandom_range(0, 1));
			RX_RUNS: begin
				if (run_left == 0) begin
					run_left  = $urandom_range(1, 10);
					run_stall = ~run_stall;
				end
				run_left--;
				rsp_ready <= !run_stall;
			end
			default:
				rsp_ready <= 1'b1;
			endcase
		end
	end

	task automatic check_field(input string name, input logic [TASK_ID_BITS-1:0] want,
			input logic [TASK_ID_BITS-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Result checker: every accepted result against the oldest expectation
	always @(posedge clk) begin : rsp_check
		fts_rsp_t want;
		if (arst_n) begin
			if (req_valid && !req_ready)
				stall_cycles++;
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h", $time, rsp);
					fail_count++;
				end else begin
					want = awaited_rsp[0];
					awaited_rsp.delete(0);
					check_field("task_valid", TASK_ID_BITS'(want.task_valid),
						TASK_ID_BITS'(rsp.task_valid));
					check_field("task_out", want.task_out, rsp.task_out);
					check_field("from_unblocked", TASK_ID_BITS'(want.from_unblocked),
						TASK_ID_BITS'(rsp.from_unblocked));
					check_field("cpu_valid", TASK_ID_BITS'(want.cpu_valid),
						TASK_ID_BITS'(rsp.cpu_valid));
					check_field("cpu_out", TASK_ID_BITS'(want.cpu_out),
						TASK_ID_BITS'(rsp.cpu_out));
					check_field("granted", TASK_ID_BITS'(want.granted),
						TASK_ID_BITS'(rsp.granted));
					check_field("overflow", TASK_ID_BITS'(want.overflow),
						TASK_ID_BITS'(rsp.overflow));
					overflows += int'(want.overflow);
					grants    += int'(want.granted);
					rsps_checked++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, awaited_rsp.size());
			$display("simulation failed");
			$finish;
		end
	end

	// Hand-picked sequence: ignored codes, parking and duplicate parking,
	// grant of the nearest copy and of a CPU that is not idle, find-idle
	// with and without force, and unblocked work served before ready work.
	task automatic test_directed();
		sender_bursty = 1'b0;
		send_req(req_of(MODE_RSVD_LO, TASK_MAX, CPU_MAX, 1'b1));
		send_req(req_of(MODE_RSVD_HI, '0, '0, 1'b0));
		send_req(req_of(MODE_FIND_IDLE, '0, '0, 1'b1));
		send_req(req_of(MODE_REQUEST, '0, '0, 1'b0));
		send_req(req_of(MODE_REQUEST, TASK_MAX, CPU_MAX, 1'b1));
		send_req(req_of(MODE_REQUEST, '0, CPU_MAX, 1'b0));
		send_req(req_of(MODE_REQUEST, '0, 4'd5, 1'b0));
		send_req(req_of(MODE_GRANT, '0, CPU_MAX, 1'b0));
		send_req(req_of(MODE_GRANT, TASK_MAX, 4'd9, 1'b1));
		send_req(req_of(MODE_FIND_IDLE, '0, '0, 1'b0));
		send_req(req_of(MODE_ADD_READY, TASK_MAX, '0, 1'b0));
		send_req(req_of(MODE_FIND_IDLE, '0, CPU_MAX, 1'b0));
		send_req(req_of(MODE_UNBLOCK, '0, '0, 1'b0));
		send_req(req_of(MODE_UNBLOCK, TASK_MAX, CPU_MAX, 1'b1));
		send_req(req_of(MODE_REQUEST, '0, 4'd3, 1'b0));
		send_req(req_of(MODE_REQUEST, '0, 4'd3, 1'b0));
		send_req(req_of(MODE_REQUEST, '0, 4'd3, 1'b0));
		send_req(req_of(MODE_ADD_READY, '0, CPU_MAX, 1'b1));
		send_req(req_of(MODE_REQUEST, TASK_MAX, CPU_MAX, 1'b0));
		send_req(req_of(MODE_RSVD_HI - 3'd1, TASK_ID_BITS'($urandom), CPU_W'($urandom),
			1'b1));
		send_req(req_of(MODE_FIND_IDLE, TASK_MAX, CPU_MAX, 1'b1));
		wait_drain();
	endtask

	// Every store driven to full and past it, plus a grant for the CPU id
	// held at the bottom entry of a full stack.
	task automatic test_store_full();
		sender_bursty = 1'b1;
		rx_style     <= RX_COIN;
		while (ready_tasks.size() + unblocked_tasks.size() != 0)
			send_req(req_of(MODE_REQUEST, TASK_ID_BITS'($urandom), CPU_W'($urandom),
				1'($urandom)));
		while (idle_cpus.size() < CPU_COUNT)
			send_req(req_of(MODE_REQUEST, TASK_ID_BITS'($urandom), CPU_W'($urandom),
				1'($urandom)));
		repeat (2) send_req(req_of(MODE_REQUEST, TASK_ID_BITS'($urandom), CPU_W'($urandom),
			1'($urandom)));
		send_req(req_of(MODE_GRANT, TASK_ID_BITS'($urandom), idle_cpus[0], 1'($urandom)));
		while (ready_tasks.size() < TASK_QUEUE_DEPTH)
			send_req(req_of(MODE_ADD_READY, TASK_ID_BITS'($urandom), CPU_W'($urandom),
				1'($urandom)));
		repeat (2) send_req(req_of(MODE_ADD_READY, TASK_ID_BITS'($urandom), CPU_W'($urandom),
			1'($urandom)));
		while (unblocked_tasks.size() < TASK_QUEUE_DEPTH)
			send_req(req_of(MODE_UNBLOCK, TASK_ID_BITS'($urandom), CPU_W'($urandom),
				1'($urandom)));
		repeat (2) send_req(req_of(MODE_UNBLOCK, TASK_ID_BITS'($urandom), CPU_W'($urandom),
			1'($urandom)));
		send_req(req_of(MODE_FIND_IDLE, TASK_ID_BITS'($urandom), CPU_W'($urandom), 1'b1));
		while (ready_tasks.size() + unblocked_tasks.size() != 0)
			send_req(req_of(MODE_REQUEST, TASK_ID_BITS'($urandom), CPU_W'($urandom),
				1'($urandom)));
		wait_drain();
	endtask

	// Receiver goes quiet for a long stretch while requests keep coming,
	// so the output register fills and the block has to stall its input.
	task automatic test_backpressure();
		sender_bursty = 1'b0;
		rx_style     <= RX_ALWAYS;
		hold_len     <= 200;
		hold_seq     <= hold_seq + 1;
		repeat (24) send_req(rand_req(MIX_BALANCED));
		wait_drain();
	endtask

	// Bulk random traffic; mix, sender pacing and receiver pattern change
	// every segment so stores swing between empty and busy.
	task automatic test_random_mix(input int n);
		mix_t mix;
		mix = MIX_BALANCED;
		for (int i = 0; i < n; i++) begin
			if (i % 120 == 0) begin
				mix           = mix_t'($urandom_range(0, 2));
				rx_style     <= rx_style_t'($urandom_range(0, 2));
				sender_bursty = ($urandom_range(0, 3) != 0);
			end
			send_req(rand_req(mix));
		end
		wait_drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_store_full();
		test_backpressure();
		test_random_mix(RANDOM_ITEMS);

		req_valid <= 1'b0;
		rx_style  <= RX_ALWAYS;
		wait_drain();
		// anything the block still emits now is unexpected and gets flagged
		repeat (SLOWEST_REQ + 8) @(posedge clk);

		$display("%0d requests sent, %0d results checked over %0d cycles",
			reqs_sent, rsps_checked, cycle_count);
		$display("%0d overflow drops, %0d grants, %0d cycles of input stall",
			overflows, grants, stall_cycles);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/fts_pkg.sv
hw/rtl/fts_ram.sv
hw/rtl/fts_ctrl.sv
hw/rtl/fts_datapath.sv
hw/rtl/fifo_task_scheduler_top.sv
hw/rtl/fts_checker.sv
test/fifo_task_scheduler_top_tb.sv
